FILE: rtl/ppcs_pkg.sv
package ppcs_pkg;

	// counter widths
	localparam int LINE_BITS  = 24;
	localparam int COUNT_BITS = 24;

	// field width of the reported counters
	localparam int FIELD_BITS = 24;

	// characters the scanner reacts to
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// prefix length and the identifier length that makes a hit
	localparam logic [3:0] PFX_LEN = 4'd11;
	localparam logic [3:0] HIT_LEN = 4'd12;

	// input word
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} src_word_t;

	// result word
	typedef struct packed {
		logic [FIELD_BITS-1:0] line_number;
		logic                  line_hit;
		logic [FIELD_BITS-1:0] hit_count;
		logic                  end_of_file;
	} res_word_t;

	// where the scan stands within a line
	typedef enum logic [2:0] {
		PH_LEAD,
		PH_HASH,
		PH_KW_IF,
		PH_KW_IFDEF,
		PH_KW_IFNDEF,
		PH_KW_ELIF,
		PH_EXPR,
		PH_OTHER
	} phase_t;

	// lexer mode within the expression part
	typedef enum logic [3:0] {
		LX_NORMAL,
		LX_IDENT,
		LX_SLASH,
		LX_STR,
		LX_STR_ESC,
		LX_CHR,
		LX_CHR_ESC,
		LX_LINE_CMT,
		LX_BLOCK,
		LX_BLOCK_STAR
	} lex_mode_t;

	// complete scanner state
	typedef struct packed {
		phase_t                phase;
		logic [2:0]            prog;
		lex_mode_t             mode;
		logic [3:0]            ident_len;
		logic                  pfx_match;
		logic                  cont_line;
		logic                  prev_bslash;
		logic                  held_cr;
		logic                  line_open;
		logic [LINE_BITS-1:0]  line_cnt;
		logic                  line_flag;
		logic [COUNT_BITS-1:0] hit_cnt;
		logic                  text_ended;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		phase:       PH_LEAD,
		prog:        3'd0,
		mode:        LX_NORMAL,
		ident_len:   4'd0,
		pfx_match:   1'b1,
		cont_line:   1'b0,
		prev_bslash: 1'b0,
		held_cr:     1'b0,
		line_open:   1'b0,
		line_cnt:    '0,
		line_flag:   1'b0,
		hit_cnt:     '0,
		text_ended:  1'b0
	};

endpackage

FILE: rtl/preproc_conditional_prefix_scan_core.sv
// channel | handshake         | word                      | direction
// src     | src_valid/ready   | text_byte, last_byte      | into block
// res     | res_valid/ready   | line_number, line_hit,    | out of block
//         |                   | hit_count, end_of_file    |
//
// One byte per cycle while src_ready is high: each accepted byte updates the lexer
// state in the same cycle, and a line end loads the result register.
// A held CR followed by a byte other than LF, NUL or CR is worked through two
// character steps in that single cycle.
// arst_n clears the scanner state and the result valid flag.
// src_ready drops only while a result waits and res_ready is low.
module preproc_conditional_prefix_scan_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  ppcs_pkg::src_word_t   src_word,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ppcs_pkg::res_word_t   res_word
);

	ppcs_pkg::scan_state_t st_q;
	ppcs_pkg::scan_state_t st_nxt;
	ppcs_pkg::res_word_t   res_q;
	ppcs_pkg::res_word_t   res_nxt;
	logic                  res_valid_q;
	logic                  res_gen;
	logic                  src_fire;

	// character classes
	function automatic logic is_alpha(logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
	endfunction

	function automatic logic is_ident(logic [7:0] c);
		return is_alpha(c) || (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == ppcs_pkg::CH_SPACE) || (c == ppcs_pkg::CH_TAB);
	endfunction

	// target prefix, one character per position
	function automatic logic [7:0] pfx_char(logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:    r = 8'h4D;
			4'd1:    r = 8'h43;
			4'd2:    r = 8'h43;
			4'd3:    r = 8'h5F;
			4'd4:    r = 8'h54;
			4'd5:    r = 8'h41;
			4'd6:    r = 8'h52;
			4'd7:    r = 8'h47;
			4'd8:    r = 8'h45;
			4'd9:    r = 8'h54;
			4'd10:   r = 8'h5F;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// keyword text by phase and position
	function automatic logic [7:0] kw_char(ppcs_pkg::phase_t ph, logic [2:0] idx);
		logic [7:0] r;
		r = 8'h00;
		case (ph)
			ppcs_pkg::PH_KW_IF: begin
				case (idx)
					3'd0:    r = 8'h69;
					3'd1:    r = 8'h66;
					default: r = 8'h00;
				endcase
			end
			ppcs_pkg::PH_KW_IFDEF: begin
				case (idx)
					3'd0:    r = 8'h69;
					3'd1:    r = 8'h66;
					3'd2:    r = 8'h64;
					3'd3:    r = 8'h65;
					3'd4:    r = 8'h66;
					default: r = 8'h00;
				endcase
			end
			ppcs_pkg::PH_KW_IFNDEF: begin
				case (idx)
					3'd0:    r = 8'h69;
					3'd1:    r = 8'h66;
					3'd2:    r = 8'h6E;
					3'd3:    r = 8'h64;
					3'd4:    r = 8'h65;
					3'd5:    r = 8'h66;
					default: r = 8'h00;
				endcase
			end
			ppcs_pkg::PH_KW_ELIF: begin
				case (idx)
					3'd0:    r = 8'h65;
					3'd1:    r = 8'h6C;
					3'd2:    r = 8'h69;
					3'd3:    r = 8'h66;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// keyword fully matched
	function automatic logic kw_done(ppcs_pkg::scan_state_t s);
		logic r;
		case (s.phase)
			ppcs_pkg::PH_KW_IF:     r = (s.prog == 3'd2);
			ppcs_pkg::PH_KW_IFDEF:  r = (s.prog == 3'd5);
			ppcs_pkg::PH_KW_IFNDEF: r = (s.prog == 3'd6);
			ppcs_pkg::PH_KW_ELIF:   r = (s.prog == 3'd4);
			default:                r = 1'b0;
		endcase
		return r;
	endfunction

	// one lexer step on the expression part
	function automatic ppcs_pkg::scan_state_t lex_byte(ppcs_pkg::scan_state_t s,
			logic [7:0] c);
		ppcs_pkg::scan_state_t r;
		ppcs_pkg::lex_mode_t   m;
		logic                  done;
		r    = s;
		m    = s.mode;
		done = 1'b0;
		if (m == ppcs_pkg::LX_IDENT) begin
			if (is_ident(c)) begin
				done = 1'b1;
				if (s.ident_len < ppcs_pkg::PFX_LEN && c != pfx_char(s.ident_len))
					r.pfx_match = 1'b0;
				if (s.ident_len < ppcs_pkg::HIT_LEN) begin
					r.ident_len = s.ident_len + 4'd1;
					if (r.ident_len == ppcs_pkg::HIT_LEN && r.pfx_match)
						r.line_flag = 1'b1;
				end
			end else begin
				m = ppcs_pkg::LX_NORMAL;
			end
		end else if (m == ppcs_pkg::LX_SLASH) begin
			if (c == ppcs_pkg::CH_SLASH) begin
				done   = 1'b1;
				r.mode = ppcs_pkg::LX_LINE_CMT;
			end else if (c == ppcs_pkg::CH_STAR) begin
				done   = 1'b1;
				r.mode = ppcs_pkg::LX_BLOCK;
			end else begin
				m = ppcs_pkg::LX_NORMAL;
			end
		end
		if (!done) begin
			r.mode = m;
			case (m)
				ppcs_pkg::LX_NORMAL: begin
					if (c == ppcs_pkg::CH_DQUOTE) r.mode = ppcs_pkg::LX_STR;
					else if (c == ppcs_pkg::CH_SQUOTE) r.mode = ppcs_pkg::LX_CHR;
					else if (c == ppcs_pkg::CH_SLASH) r.mode = ppcs_pkg::LX_SLASH;
					else if (is_alpha(c)) begin
						// first character of an identifier
						r.mode      = ppcs_pkg::LX_IDENT;
						r.ident_len = 4'd1;
						r.pfx_match = (c == pfx_char(4'd0));
					end
				end
				ppcs_pkg::LX_STR: begin
					if (c == ppcs_pkg::CH_BSLASH) r.mode = ppcs_pkg::LX_STR_ESC;
					else if (c == ppcs_pkg::CH_DQUOTE) r.mode = ppcs_pkg::LX_NORMAL;
				end
				ppcs_pkg::LX_STR_ESC: r.mode = ppcs_pkg::LX_STR;
				ppcs_pkg::LX_CHR: begin
					if (c == ppcs_pkg::CH_BSLASH) r.mode = ppcs_pkg::LX_CHR_ESC;
					else if (c == ppcs_pkg::CH_SQUOTE) r.mode = ppcs_pkg::LX_NORMAL;
				end
				ppcs_pkg::LX_CHR_ESC: r.mode = ppcs_pkg::LX_CHR;
				ppcs_pkg::LX_BLOCK: begin
					if (c == ppcs_pkg::CH_STAR) r.mode = ppcs_pkg::LX_BLOCK_STAR;
				end
				ppcs_pkg::LX_BLOCK_STAR: begin
					if (c == ppcs_pkg::CH_SLASH) r.mode = ppcs_pkg::LX_NORMAL;
					else if (c != ppcs_pkg::CH_STAR) r.mode = ppcs_pkg::LX_BLOCK;
				end
				default: r.mode = m;
			endcase
		end
		return r;
	endfunction

	// one character into the line: directive match, then the lexer
	function automatic ppcs_pkg::scan_state_t feed(ppcs_pkg::scan_state_t s,
			logic [7:0] c);
		ppcs_pkg::scan_state_t r;
		r             = s;
		r.line_open   = 1'b1;
		r.prev_bslash = (c == ppcs_pkg::CH_BSLASH);
		case (s.phase)
			ppcs_pkg::PH_LEAD: begin
				if (c == ppcs_pkg::CH_HASH) r.phase = ppcs_pkg::PH_HASH;
				else if (!is_blank(c)) r.phase = ppcs_pkg::PH_OTHER;
			end
			ppcs_pkg::PH_HASH: begin
				if (c == kw_char(ppcs_pkg::PH_KW_IF, 3'd0)) begin
					r.phase = ppcs_pkg::PH_KW_IF;
					r.prog  = 3'd1;
				end else if (c == kw_char(ppcs_pkg::PH_KW_ELIF, 3'd0)) begin
					r.phase = ppcs_pkg::PH_KW_ELIF;
					r.prog  = 3'd1;
				end else if (!is_blank(c)) begin
					r.phase = ppcs_pkg::PH_OTHER;
				end
			end
			ppcs_pkg::PH_EXPR: r = lex_byte(r, c);
			ppcs_pkg::PH_OTHER: r.phase = ppcs_pkg::PH_OTHER;
			default: begin
				// keyword phases
				if (s.phase == ppcs_pkg::PH_KW_IF && s.prog == 3'd2
						&& (c == kw_char(ppcs_pkg::PH_KW_IFDEF, 3'd2)
						|| c == kw_char(ppcs_pkg::PH_KW_IFNDEF, 3'd2))) begin
					r.phase = (c == kw_char(ppcs_pkg::PH_KW_IFDEF, 3'd2))
						? ppcs_pkg::PH_KW_IFDEF : ppcs_pkg::PH_KW_IFNDEF;
					r.prog  = 3'd3;
				end else if (kw_done(s)) begin
					if (is_ident(c)) r.phase = ppcs_pkg::PH_OTHER;
					else begin
						r.phase = ppcs_pkg::PH_EXPR;
						r       = lex_byte(r, c);
					end
				end else if (s.prog < 3'd6 && c == kw_char(s.phase, s.prog)) begin
					r.prog = s.prog + 3'd1;
				end else begin
					r.phase = ppcs_pkg::PH_OTHER;
				end
			end
		endcase
		return r;
	endfunction

	// counters to result field width
	function automatic logic [ppcs_pkg::FIELD_BITS-1:0] line_field(
			logic [ppcs_pkg::LINE_BITS-1:0] v);
		logic [ppcs_pkg::LINE_BITS+ppcs_pkg::FIELD_BITS-1:0] w;
		w = {{ppcs_pkg::FIELD_BITS{1'b0}}, v};
		return w[ppcs_pkg::FIELD_BITS-1:0];
	endfunction

	function automatic logic [ppcs_pkg::FIELD_BITS-1:0] count_field(
			logic [ppcs_pkg::COUNT_BITS-1:0] v);
		logic [ppcs_pkg::COUNT_BITS+ppcs_pkg::FIELD_BITS-1:0] w;
		w = {{ppcs_pkg::FIELD_BITS{1'b0}}, v};
		return w[ppcs_pkg::FIELD_BITS-1:0];
	endfunction

	// close a line: counters, result word, fresh line state
	function automatic ppcs_pkg::scan_state_t end_line(ppcs_pkg::scan_state_t s,
			logic eof, output ppcs_pkg::res_word_t w);
		ppcs_pkg::scan_state_t r;
		logic                  counts;
		logic                  hit;
		r      = s;
		counts = s.cont_line || s.phase == ppcs_pkg::PH_EXPR || kw_done(s);
		hit    = counts && s.line_flag;
		if (s.line_cnt != {ppcs_pkg::LINE_BITS{1'b1}})
			r.line_cnt = s.line_cnt + {{(ppcs_pkg::LINE_BITS-1){1'b0}}, 1'b1};
		if (hit && s.hit_cnt != {ppcs_pkg::COUNT_BITS{1'b1}})
			r.hit_cnt = s.hit_cnt + {{(ppcs_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
		r.cont_line   = counts && s.prev_bslash;
		w.line_number = line_field(r.line_cnt);
		w.line_hit    = hit;
		w.hit_count   = count_field(r.hit_cnt);
		w.end_of_file = eof;
		r.phase       = r.cont_line ? ppcs_pkg::PH_EXPR : ppcs_pkg::PH_LEAD;
		r.prog        = 3'd0;
		r.mode        = ppcs_pkg::LX_NORMAL;
		r.ident_len   = 4'd0;
		r.pfx_match   = 1'b1;
		r.prev_bslash = 1'b0;
		r.held_cr     = 1'b0;
		r.line_flag   = 1'b0;
		r.line_open   = 1'b0;
		return r;
	endfunction

	assign src_ready = !res_valid_q || res_ready;
	assign src_fire  = src_valid && src_ready;

	// per-byte scanner step
	always_comb begin
		ppcs_pkg::scan_state_t s;
		logic [7:0]            c;
		logic                  last;
		s       = st_q;
		c       = src_word.text_byte;
		last    = src_word.last_byte;
		res_gen = 1'b0;
		res_nxt = res_q;
		if (st_q.text_ended) begin
			// text over: wait for the file's last byte
			if (last) s = ppcs_pkg::SCAN_RESET;
		end else if (c == ppcs_pkg::CH_NUL) begin
			s.held_cr = 1'b0;
			if (s.line_open) begin
				s       = end_line(s, 1'b1, res_nxt);
				res_gen = 1'b1;
			end
			s            = ppcs_pkg::SCAN_RESET;
			s.text_ended = !last;
		end else if (c == ppcs_pkg::CH_LF) begin
			s.held_cr = 1'b0;
			s         = end_line(s, last, res_nxt);
			res_gen   = 1'b1;
			if (last) s = ppcs_pkg::SCAN_RESET;
		end else begin
			// a held CR turns out to be an ordinary character
			if (s.held_cr) begin
				s.held_cr = 1'b0;
				s         = feed(s, ppcs_pkg::CH_CR);
			end
			if (c == ppcs_pkg::CH_CR) begin
				s.held_cr   = 1'b1;
				s.line_open = 1'b1;
			end else begin
				s = feed(s, c);
			end
			if (last) begin
				s.held_cr = 1'b0;
				s         = end_line(s, 1'b1, res_nxt);
				res_gen   = 1'b1;
				s         = ppcs_pkg::SCAN_RESET;
			end
		end
		st_nxt = s;
	end

	// scanner state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ppcs_pkg::SCAN_RESET;
		end else if (src_fire) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (src_fire) begin
			res_valid_q <= res_gen;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_fire && res_gen) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

`ifndef SYNTHESIS
	// a new result only follows an accepted byte
	a_res_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(src_valid && src_ready))
		else $error("result appeared without an accepted byte");

	// hit lines never outnumber lines
	a_hits_le_lines: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.hit_count <= res_word.line_number))
		else $error("hit count above line number");

	// a hit line is counted
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.line_hit) |-> (res_word.hit_count != '0))
		else $error("hit line with zero hit count");

	// a zero byte before the last one ends the text
	a_nul_ends_text: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready && !st_q.text_ended
		&& src_word.text_byte == ppcs_pkg::CH_NUL && !src_word.last_byte)
		|=> st_q.text_ended)
		else $error("zero byte did not end the text");
`endif

endmodule
